[hw/rtl/mfl_pkg.sv]
package mfl_pkg;

   // Result codes.
   localparam logic [1:0] REASON_HEADER    = 2'd0;
   localparam logic [1:0] REASON_NO_PREFIX = 2'd1;
   localparam logic [1:0] REASON_MISSING   = 2'd2;
   localparam logic [1:0] REASON_BAD_DATE  = 2'd3;

   // Character classes used by the date templates.
   localparam logic [2:0] CLS_UPPER = 3'd0;
   localparam logic [2:0] CLS_LOWER = 3'd1;
   localparam logic [2:0] CLS_SPACE = 3'd2;
   localparam logic [2:0] CLS_DIGIT = 3'd3;
   localparam logic [2:0] CLS_OPT   = 3'd4;
   localparam logic [2:0] CLS_COLON = 3'd5;

   // Characters of interest.
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   // Date lengths of the two templates, and the saturation point.
   localparam logic [4:0] PLAIN_LEN = 5'd24;
   localparam logic [4:0] ZONED_LEN = 5'd28;
   localparam logic [4:0] DATE_SAT  = 5'd29;

   // Result word handed from the scanner to the output register.
   typedef struct packed {
      logic       is_header;
      logic [1:0] reason;
      logic       tty_seen;
   } mfl_result_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic class_ok(input logic [2:0] k, input logic [7:0] c);
      logic ok;
      case (k)
         CLS_UPPER: ok = (c >= "A") && (c <= "Z");
         CLS_LOWER: ok = (c >= "a") && (c <= "z");
         CLS_SPACE: ok = (c == CHAR_SPACE);
         CLS_DIGIT: ok = is_digit(c);
         CLS_OPT:   ok = (c == CHAR_SPACE) || is_digit(c);
         default:   ok = (c == CHAR_COLON);
      endcase
      return ok;
   endfunction

   // Characters of the "From " prefix.
   function automatic logic [7:0] prefix_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = "F";
         3'd1:    c = "r";
         3'd2:    c = "o";
         3'd3:    c = "m";
         default: c = CHAR_SPACE;
      endcase
      return c;
   endfunction

   // Characters of the "tty" word start.
   function automatic logic [7:0] tty_char(input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0:    c = "t";
         2'd1:    c = "t";
         default: c = "y";
      endcase
      return c;
   endfunction

   // Class of each position of the date templates. The two share their first
   // twenty positions; the zoned one carries a zone word before the year.
   function automatic logic [2:0] date_class(input logic [4:0] pos, input logic zoned);
      logic [2:0] k;
      case (pos)
         5'd0, 5'd4:                                k = CLS_UPPER;
         5'd1, 5'd2, 5'd5, 5'd6:                    k = CLS_LOWER;
         5'd3, 5'd7, 5'd10, 5'd19:                  k = CLS_SPACE;
         5'd8:                                      k = CLS_OPT;
         5'd13, 5'd16:                              k = CLS_COLON;
         5'd20, 5'd21, 5'd22:                       k = zoned ? CLS_UPPER : CLS_DIGIT;
         5'd23:                                     k = zoned ? CLS_SPACE : CLS_DIGIT;
         default:                                   k = CLS_DIGIT;
      endcase
      return k;
   endfunction

endpackage

[hw/rtl/mailbox_from_line_recognizer_top.sv]
// Mailbox header line recogniser: one text byte per word, verdict on the line-end word.
// Throughput: one word per cycle, set by the update of the scan state, unless a line end stalls.
// An accepted line-end word is held in the input register; its verdict then goes to the result register.
// Bytes move on while a result waits; only a second line end then stalls the input.
// Reset (synchronous, active high) empties both registers and returns the scan to
// the prefix check at position zero.
module mailbox_from_line_recognizer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_ch,
   input  logic       req_line_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_is_header,
   output logic [1:0] rsp_reason,
   output logic       rsp_tty_seen
);

   logic       in_valid_ff;
   logic [7:0] in_ch_ff;
   logic       in_end_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_free, advance;

   mfl_pkg::mfl_result_type scan_result;
   mfl_pkg::mfl_result_type rsp_ff;

   // The held word moves on unless it is a line end and the result register is full.
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!in_end_ff || rsp_free);
   assign req_stall = in_valid_ff && !advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ch_ff  <= req_ch;
         in_end_ff <= req_line_end;
      end
   end

   mfl_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .ch       (in_ch_ff),
      .line_end (in_end_ff),
      .result   (scan_result)
   );

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && in_end_ff) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_end_ff) begin
         rsp_ff <= scan_result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_is_header = rsp_ff.is_header;
   assign rsp_reason    = rsp_ff.reason;
   assign rsp_tty_seen  = rsp_ff.tty_seen;

endmodule

[hw/rtl/mfl_scan.sv]
module mfl_scan (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              ch,
   input  logic                    line_end,
   output mfl_pkg::mfl_result_type result
);

   localparam logic [3:0] PH_PREFIX = 4'd0;
   localparam logic [3:0] PH_BLANK1 = 4'd1;
   localparam logic [3:0] PH_SENDER = 4'd2;
   localparam logic [3:0] PH_BLANK2 = 4'd3;
   localparam logic [3:0] PH_THIRD  = 4'd4;
   localparam logic [3:0] PH_TTYW   = 4'd5;
   localparam logic [3:0] PH_BLANK3 = 4'd6;
   localparam logic [3:0] PH_DATE   = 4'd7;
   localparam logic [3:0] PH_REJECT = 4'd8;

   logic [3:0] phase_ff, phase_in;
   logic [2:0] prefix_pos_ff, prefix_pos_in;
   logic [4:0] date_pos_ff, date_pos_in;
   logic       plain_ok_ff, plain_ok_in;
   logic       zoned_ok_ff, zoned_ok_in;
   logic       in_quote_ff, in_quote_in;
   logic [1:0] tty_cnt_ff, tty_cnt_in;
   logic       stopped_ff, stopped_in;

   logic [4:0] date_pos_fed;
   logic       plain_ok_fed, zoned_ok_fed;
   logic       word_done, quote_fed;
   logic       blank, tty_hit, date_good;

   // One date character checked against both templates.
   always_comb begin
      plain_ok_fed = plain_ok_ff && (date_pos_ff < mfl_pkg::PLAIN_LEN) &&
                     mfl_pkg::class_ok(mfl_pkg::date_class(date_pos_ff, 1'b0), ch);
      zoned_ok_fed = zoned_ok_ff && (date_pos_ff < mfl_pkg::ZONED_LEN) &&
                     mfl_pkg::class_ok(mfl_pkg::date_class(date_pos_ff, 1'b1), ch);
      date_pos_fed = (date_pos_ff < mfl_pkg::DATE_SAT) ? date_pos_ff + 5'd1 : date_pos_ff;
   end

   // Word scanning: a blank outside quotes ends the word.
   assign blank     = mfl_pkg::is_blank(ch);
   assign word_done = !in_quote_ff && blank;
   assign quote_fed = in_quote_ff ? (ch != mfl_pkg::CHAR_QUOTE) : (ch == mfl_pkg::CHAR_QUOTE);
   assign tty_hit   = (tty_cnt_ff != 2'd3) && (ch == mfl_pkg::tty_char(tty_cnt_ff));

   assign date_good = (plain_ok_ff && (date_pos_ff == mfl_pkg::PLAIN_LEN)) ||
                      (zoned_ok_ff && (date_pos_ff == mfl_pkg::ZONED_LEN));

   // Verdict for a line end, taken from the state left by the line.
   always_comb begin
      result.tty_seen = (tty_cnt_ff == 2'd3);
      case (phase_ff)
         PH_PREFIX, PH_REJECT: begin
            result.reason   = mfl_pkg::REASON_NO_PREFIX;
            result.tty_seen = 1'b0;
         end
         PH_THIRD, PH_DATE: begin
            result.reason = date_good ? mfl_pkg::REASON_HEADER : mfl_pkg::REASON_BAD_DATE;
         end
         default: begin
            result.reason = mfl_pkg::REASON_MISSING;
         end
      endcase
      result.is_header = (result.reason == mfl_pkg::REASON_HEADER);
   end

   // Next state for one word.
   always_comb begin
      phase_in      = phase_ff;
      prefix_pos_in = prefix_pos_ff;
      date_pos_in   = date_pos_ff;
      plain_ok_in   = plain_ok_ff;
      zoned_ok_in   = zoned_ok_ff;
      in_quote_in   = in_quote_ff;
      tty_cnt_in    = tty_cnt_ff;
      stopped_in    = stopped_ff;
      if (line_end) begin
         phase_in      = PH_PREFIX;
         prefix_pos_in = 3'd0;
         date_pos_in   = 5'd0;
         plain_ok_in   = 1'b1;
         zoned_ok_in   = 1'b1;
         in_quote_in   = 1'b0;
         tty_cnt_in    = 2'd0;
         stopped_in    = 1'b0;
      end else if (stopped_ff) begin
         // Text already ended; bytes are ignored until the line end.
         stopped_in = 1'b1;
      end else if (ch == mfl_pkg::CHAR_NUL) begin
         stopped_in = 1'b1;
      end else begin
         case (phase_ff)
            PH_PREFIX: begin
               if (ch == mfl_pkg::prefix_char(prefix_pos_ff)) begin
                  prefix_pos_in = prefix_pos_ff + 3'd1;
                  if (prefix_pos_ff == 3'd4) begin
                     phase_in = PH_BLANK1;
                  end
               end else begin
                  phase_in = PH_REJECT;
               end
            end
            PH_BLANK1: begin
               if (!blank) begin
                  phase_in    = PH_SENDER;
                  in_quote_in = quote_fed;
               end
            end
            PH_SENDER, PH_TTYW: begin
               if (word_done) begin
                  phase_in = (phase_ff == PH_SENDER) ? PH_BLANK2 : PH_BLANK3;
               end else begin
                  in_quote_in = quote_fed;
               end
            end
            PH_BLANK2, PH_THIRD: begin
               if (!blank || (phase_ff == PH_THIRD)) begin
                  date_pos_in = date_pos_fed;
                  plain_ok_in = plain_ok_fed;
                  zoned_ok_in = zoned_ok_fed;
                  if (tty_hit) begin
                     tty_cnt_in = tty_cnt_ff + 2'd1;
                     phase_in   = PH_THIRD;
                     // A complete tty start makes this word the tty word.
                     if (tty_cnt_ff == 2'd2) begin
                        date_pos_in = 5'd0;
                        plain_ok_in = 1'b1;
                        zoned_ok_in = 1'b1;
                        phase_in    = PH_TTYW;
                     end
                  end else begin
                     phase_in = PH_DATE;
                  end
               end
            end
            PH_BLANK3: begin
               if (!blank) begin
                  phase_in    = PH_DATE;
                  date_pos_in = date_pos_fed;
                  plain_ok_in = plain_ok_fed;
                  zoned_ok_in = zoned_ok_fed;
               end
            end
            PH_DATE: begin
               date_pos_in = date_pos_fed;
               plain_ok_in = plain_ok_fed;
               zoned_ok_in = zoned_ok_fed;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // Scan state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_PREFIX;
         prefix_pos_ff <= 3'd0;
         date_pos_ff   <= 5'd0;
         plain_ok_ff   <= 1'b1;
         zoned_ok_ff   <= 1'b1;
         in_quote_ff   <= 1'b0;
         tty_cnt_ff    <= 2'd0;
         stopped_ff    <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         prefix_pos_ff <= prefix_pos_in;
         date_pos_ff   <= date_pos_in;
         plain_ok_ff   <= plain_ok_in;
         zoned_ok_ff   <= zoned_ok_in;
         in_quote_ff   <= in_quote_in;
         tty_cnt_ff    <= tty_cnt_in;
         stopped_ff    <= stopped_in;
      end
   end

endmodule

[hw/rtl/mfl_checker.sv]
module mfl_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_line_end,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_is_header,
   input logic [1:0] rsp_reason,
   input logic       rsp_tty_seen
);

   // A stalled result word stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   // The header flag agrees with the reason code.
   a_flag_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_header == (rsp_reason == mfl_pkg::REASON_HEADER)))
      else $error("header flag disagrees with reason");

   // A line without the prefix never reports a tty word.
   a_no_prefix_tty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_reason == mfl_pkg::REASON_NO_PREFIX) |-> !rsp_tty_seen)
      else $error("tty reported on a line without the prefix");

   // A fresh result follows an accepted line-end word, by way of the input and result registers.
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_line_end, 2))
      else $error("result word without a line end");

endmodule

bind mailbox_from_line_recognizer_top mfl_checker u_mfl_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_line_end  (req_line_end),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_is_header (rsp_is_header),
   .rsp_reason    (rsp_reason),
   .rsp_tty_seen  (rsp_tty_seen)
);

[tb/mfl_scan_checker.sv]
`timescale 1ns / 100ps

// Watches both channels of the header recogniser, predicts the verdict of every line
// and compares each verdict word that leaves the block with the oldest prediction.
module mfl_scan_checker
   import mfl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_ch,
   input  logic       req_line_end,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_is_header,
   input  logic [1:0] rsp_reason,
   input  logic       rsp_tty_seen,
   output int         fail_total,
   output int         verdicts_owed
);

   // Where the scan stands within the current line.
   typedef enum logic [3:0] {
      SCAN_PREFIX, SCAN_GAP1, SCAN_SENDER, SCAN_GAP2, SCAN_THIRD,
      SCAN_TTY_WORD, SCAN_GAP3, SCAN_DATE, SCAN_REJECT
   } scan_phase_e;

   // Letters of the date forms: upper, lower, space, digit, digit or space, colon.
   localparam logic [7:0] T_UPPER = "U";
   localparam logic [7:0] T_LOWER = "L";
   localparam logic [7:0] T_SPACE = "S";
   localparam logic [7:0] T_DIGIT = "D";
   localparam logic [7:0] T_OPT   = "O";

   localparam logic [8*24-1:0] PLAIN_FORM = "ULLSULLSODSDDCDDCDDSDDDD";
   localparam logic [8*28-1:0] ZONED_FORM = "ULLSULLSODSDDCDDCDDSUUUSDDDD";
   localparam logic [8*5-1:0]  FROM_WORD  = "From ";
   localparam logic [8*3-1:0]  TTY_WORD   = "tty";
   localparam int              REPORT_MAX = 10;

   scan_phase_e    phase;
   int             from_pos;
   int             date_len;
   int             tty_hits;
   bit             plain_ok;
   bit             zoned_ok;
   bit             quoted;
   bit             stopped;
   mfl_result_type verdict_q[$];
   int             failures = 0;

   function automatic logic gap_char(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB);
   endfunction

   function automatic logic fits_class(input logic [7:0] k, input logic [7:0] c);
      logic ok;
      case (k)
         T_UPPER: ok = (c >= "A") && (c <= "Z");
         T_LOWER: ok = (c >= "a") && (c <= "z");
         T_SPACE: ok = (c == CHAR_SPACE);
         T_DIGIT: ok = (c >= "0") && (c <= "9");
         T_OPT:   ok = (c == CHAR_SPACE) || ((c >= "0") && (c <= "9"));
         default: ok = (c == CHAR_COLON);
      endcase
      return ok;
   endfunction

   task automatic clear_date();
      date_len = 0;
      plain_ok = 1'b1;
      zoned_ok = 1'b1;
   endtask

   task automatic clear_scan();
      phase    = SCAN_PREFIX;
      from_pos = 0;
      clear_date();
      quoted   = 1'b0;
      tty_hits = 0;
      stopped  = 1'b0;
   endtask

   // One date character against both forms; the length saturates past the longer one.
   task automatic date_step(input logic [7:0] c);
      if (date_len < PLAIN_LEN) begin
         if (!fits_class(PLAIN_FORM[8*(PLAIN_LEN-1-date_len) +: 8], c)) plain_ok = 1'b0;
      end else begin
         plain_ok = 1'b0;
      end
      if (date_len < ZONED_LEN) begin
         if (!fits_class(ZONED_FORM[8*(ZONED_LEN-1-date_len) +: 8], c)) zoned_ok = 1'b0;
      end else begin
         zoned_ok = 1'b0;
      end
      if (date_len < DATE_SAT) date_len++;
   endtask

   // A blank ends a word unless it sits between double quotes.
   task automatic word_step(input logic [7:0] c, output bit ends);
      ends = 1'b0;
      if (quoted) begin
         if (c == CHAR_QUOTE) quoted = 1'b0;
      end else if (gap_char(c)) begin
         ends = 1'b1;
      end else if (c == CHAR_QUOTE) begin
         quoted = 1'b1;
      end
   endtask

   // The third word is a date unless it opens with tty, in which case the date restarts.
   task automatic third_step(input logic [7:0] c);
      date_step(c);
      if (tty_hits < 3 && c == TTY_WORD[8*(2-tty_hits) +: 8]) begin
         tty_hits++;
         if (tty_hits == 3) begin
            clear_date();
            phase = SCAN_TTY_WORD;
         end
      end else begin
         phase = SCAN_DATE;
      end
   endtask

   // Advances the scan by one word and yields the verdict on a line end.
   task automatic scan_word(input logic [7:0] c, input logic last, output bit owed,
                            output mfl_result_type v);
      bit         ends;
      logic [1:0] why;
      owed = 1'b0;
      v    = '0;
      if (last) begin
         case (phase)
            SCAN_PREFIX, SCAN_REJECT: why = REASON_NO_PREFIX;
            SCAN_THIRD, SCAN_DATE:
               why = ((plain_ok && date_len == PLAIN_LEN) ||
                      (zoned_ok && date_len == ZONED_LEN)) ? REASON_HEADER : REASON_BAD_DATE;
            default: why = REASON_MISSING;
         endcase
         v.is_header = (why == REASON_HEADER);
         v.reason    = why;
         v.tty_seen  = (why != REASON_NO_PREFIX) && (tty_hits == 3);
         owed        = 1'b1;
         clear_scan();
      end else if (!stopped) begin
         if (c == CHAR_NUL) begin
            stopped = 1'b1;
         end else begin
            case (phase)
               SCAN_PREFIX: begin
                  if (from_pos < 5 && c == FROM_WORD[8*(4-from_pos) +: 8]) begin
                     from_pos++;
                     if (from_pos == 5) phase = SCAN_GAP1;
                  end else begin
                     phase = SCAN_REJECT;
                  end
               end
               SCAN_GAP1: begin
                  if (!gap_char(c)) begin
                     phase = SCAN_SENDER;
                     word_step(c, ends);
                  end
               end
               SCAN_SENDER: begin
                  word_step(c, ends);
                  if (ends) phase = SCAN_GAP2;
               end
               SCAN_GAP2: begin
                  if (!gap_char(c)) begin
                     phase = SCAN_THIRD;
                     third_step(c);
                  end
               end
               SCAN_THIRD: third_step(c);
               SCAN_TTY_WORD: begin
                  word_step(c, ends);
                  if (ends) phase = SCAN_GAP3;
               end
               SCAN_GAP3: begin
                  if (!gap_char(c)) begin
                     phase = SCAN_DATE;
                     date_step(c);
                  end
               end
               SCAN_DATE: date_step(c);
               default: ;
            endcase
         end
      end
   endtask

   task automatic note_failure(input string msg);
      failures++;
      if (failures <= REPORT_MAX) $display("%0t: %s", $realtime, msg);
   endtask

   // Verdicts leaving the block are checked before the line end of this edge is scanned.
   always @(posedge clock) begin : watch
      bit             owed;
      mfl_result_type want;
      if (reset) begin
         clear_scan();
         verdict_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               note_failure($sformatf("unexpected verdict word: is_header=%0d reason=%0d tty_seen=%0d",
                                      rsp_is_header, rsp_reason, rsp_tty_seen));
            end else begin
               want = verdict_q.pop_front();
               if (want.is_header !== rsp_is_header || want.reason !== rsp_reason ||
                   want.tty_seen !== rsp_tty_seen) begin
                  note_failure($sformatf({"verdict mismatch: expected is_header=%0d reason=%0d ",
                                          "tty_seen=%0d, got is_header=%0d reason=%0d tty_seen=%0d"},
                                         want.is_header, want.reason, want.tty_seen,
                                         rsp_is_header, rsp_reason, rsp_tty_seen));
               end
            end
         end
         if (req_valid && !req_stall) begin
            scan_word(req_ch, req_line_end, owed, want);
            if (owed) verdict_q.push_back(want);
         end
      end
      fail_total    <= failures;
      verdicts_owed <= verdict_q.size();
   end

endmodule

[tb/mailbox_from_line_recognizer_top_tb.sv]
`timescale 1ns / 100ps

module mailbox_from_line_recognizer_top_tb;
   import mfl_pkg::*;

   localparam int HOLD_CYCLES = 150;

   // Kinds of damage done to an otherwise well-formed random line.
   typedef enum int {FAULT_FLIP, FAULT_CUT, FAULT_NUL, FAULT_LONGER, FAULT_DROP} line_fault_e;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_ch;
   logic       req_line_end;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_is_header;
   logic [1:0] rsp_reason;
   logic       rsp_tty_seen;

   int         fail_total;
   int         verdicts_owed;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   bit         hold_req = 1'b0;
   bit         hold_seen = 1'b0;
   int         hold_left = 0;
   int         words_sent = 0;
   int         lines_sent = 0;
   logic [7:0] line_buf[$];

   mailbox_from_line_recognizer_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_ch        (req_ch),
      .req_line_end  (req_line_end),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_is_header (rsp_is_header),
      .rsp_reason    (rsp_reason),
      .rsp_tty_seen  (rsp_tty_seen)
   );

   mfl_scan_checker scan_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_ch        (req_ch),
      .req_line_end  (req_line_end),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_is_header (rsp_is_header),
      .rsp_reason    (rsp_reason),
      .rsp_tty_seen  (rsp_tty_seen),
      .fail_total    (fail_total),
      .verdicts_owed (verdicts_owed)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Receiver: random stalls, or a long hold-off whenever one is requested.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Offers one word, at times after a random gap, and returns at the edge that accepts it.
   task automatic send_word(input logic [7:0] c, input logic last);
      int gap;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(3, 1);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_ch       <= c;
      req_line_end <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   // Sends the buffered line followed by its line-end word.
   task automatic send_line();
      foreach (line_buf[i]) send_word(line_buf[i], 1'b0);
      send_word(8'($urandom_range(255)), 1'b1);
      lines_sent++;
      line_buf.delete();
   endtask

   // Holds the sender back until every verdict has come out.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (verdicts_owed != 0);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endtask

   task automatic add_blanks();
      repeat ($urandom_range(3, 1))
         line_buf.push_back($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
   endtask

   // A word of printable characters other than blanks and quotes, now and then a high byte.
   task automatic add_word();
      repeat ($urandom_range(6, 1)) begin
         if ($urandom_range(7) == 0) line_buf.push_back(8'($urandom_range(8'hFF, 8'h80)));
         else line_buf.push_back(8'($urandom_range(8'h7E, 8'h23)));
      end
   endtask

   function automatic logic [7:0] up_char();
      return 8'($urandom_range("Z", "A"));
   endfunction

   function automatic logic [7:0] low_char();
      return 8'($urandom_range("z", "a"));
   endfunction

   function automatic logic [7:0] dig_char();
      return 8'($urandom_range("9", "0"));
   endfunction

   // A random date in the plain or the zoned form.
   task automatic add_date();
      bit zoned;
      zoned = 1'($urandom_range(1));
      repeat (2) begin
         line_buf.push_back(up_char());
         line_buf.push_back(low_char());
         line_buf.push_back(low_char());
         line_buf.push_back(CHAR_SPACE);
      end
      line_buf.push_back($urandom_range(1) ? CHAR_SPACE : dig_char());
      line_buf.push_back(dig_char());
      for (int i = 0; i < 3; i++) begin
         line_buf.push_back(i == 0 ? CHAR_SPACE : CHAR_COLON);
         line_buf.push_back(dig_char());
         line_buf.push_back(dig_char());
      end
      line_buf.push_back(CHAR_SPACE);
      if (zoned) begin
         repeat (3) line_buf.push_back(up_char());
         line_buf.push_back(CHAR_SPACE);
      end
      repeat (4) line_buf.push_back(dig_char());
   endtask

   // Mostly well-formed lines with random content; some noise and some damaged lines.
   task automatic build_line();
      int          kind;
      int          shape;
      int          pos;
      line_fault_e fault;
      kind = $urandom_range(99);
      if (kind < 10) begin
         repeat ($urandom_range(12)) line_buf.push_back(8'($urandom_range(255)));
      end else begin
         add_text("From ");
         if ($urandom_range(3) == 0) add_blanks();
         if ($urandom_range(9) == 0) begin
            // The quote is never closed, so the sender swallows the rest of the line.
            line_buf.push_back(CHAR_QUOTE);
            add_word();
            add_blanks();
         end else if ($urandom_range(3) == 0) begin
            line_buf.push_back(CHAR_QUOTE);
            add_word();
            add_blanks();
            add_word();
            line_buf.push_back(CHAR_QUOTE);
         end else begin
            add_word();
         end
         shape = $urandom_range(9);
         if (shape == 0) begin
            if ($urandom_range(1)) add_blanks();
         end else begin
            add_blanks();
            if (shape == 1 || $urandom_range(2) == 0) begin
               add_text("tty");
               if ($urandom_range(1)) add_word();
               if (shape != 1) begin
                  add_blanks();
                  add_date();
               end else if ($urandom_range(1)) begin
                  add_blanks();
               end
            end else begin
               add_date();
            end
         end
         if (kind >= 75) begin
            pos   = $urandom_range(line_buf.size() - 1);
            fault = line_fault_e'($urandom_range(4));
            case (fault)
               FAULT_FLIP:   line_buf[pos] = 8'($urandom_range(255));
               FAULT_CUT:    while (line_buf.size() > pos) void'(line_buf.pop_back());
               FAULT_NUL:    line_buf.insert(pos, CHAR_NUL);
               FAULT_LONGER: repeat ($urandom_range(3, 1)) line_buf.push_back(dig_char());
               default:      line_buf.delete(pos);
            endcase
         end
      end
   endtask

   task automatic send_random(input int word_goal, input int line_goal);
      while (words_sent < word_goal || lines_sent < line_goal) begin
         build_line();
         send_line();
      end
   endtask

   // Stimulus and verdict.
   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_ch       = '0;
      req_line_end = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 29;
      recv_idle_pct <= 77;

      // Short lines and lines without a date.
      send_line();
      add_text("Fro"); send_line();
      line_buf.push_back(CHAR_NUL); add_text("From joe"); send_line();
      add_text("From "); send_line();
      add_text("From joe"); send_line();
      add_text("From joe \t"); send_line();
      add_text("From joe tty"); send_line();
      add_text("From joe ttyS1 \t"); send_line();
      add_text("From joe"); line_buf.push_back(CHAR_NUL);
      add_text(" Mon Jan  1 00:00:00 1990"); send_line();

      // Good headers, blanks of both kinds, a quoted sender and extreme sender bytes.
      add_text("From joe Mon Jan  1 00:00:00 1990"); send_line();
      add_text("From  \t\"a b\"\ttty07  Sat Dec 31 23:59:59 PST 2099"); send_line();
      add_text("From ");
      line_buf.push_back(8'hFF); line_buf.push_back(8'h80); line_buf.push_back(8'h7F);
      add_text(" Wed Mar 15 12:00:00 EST 2001"); send_line();
      add_text("From joe Mon Jan  1 00:00:00 1990"); line_buf.push_back(CHAR_NUL);
      line_buf.push_back(8'hFF); add_text(" junk"); send_line();

      // Broken prefix, open quote, wrong or over-long dates.
      add_text("From\tjoe Mon Jan  1 00:00:00 1990"); send_line();
      add_text("From \"joe Mon Jan  1 00:00:00 1990"); send_line();
      add_text("From joe Mon Jan  1 00:00:00 19901"); send_line();
      add_text("From joe Mon Jan 01 00:00:00 1990 EXTRA TEXT"); send_line();
      add_text("From joe mon Jan  1 00:00:00 1990"); send_line();
      add_text("From joe tt Mon Jan  1 00:00:00 1990"); send_line();

      send_random(420, 0);

      // The receiver holds off long enough for the block to back up into the sender.
      hold_req <= ~hold_req;
      repeat (8) begin
         add_text("From ");
         add_word();
         send_line();
      end
      drain();

      send_idle_pct = 77;
      recv_idle_pct <= 29;
      send_random(840, 0);
      drain();

      send_idle_pct = 0;
      recv_idle_pct <= 0;
      send_random(1250, 60);

      drain();
      repeat (8) @(posedge clock);
      if (fail_total == 0 && verdicts_owed == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
